[rtl/anp_pkg.sv]
// Package for the ASCII unsigned number parser: phase and status codes,
// character constants, the per-string control flags and character helpers.
// Depends on nothing; every file of the parser imports it.
package anp_pkg;

   localparam int unsigned VALUE_BITS_DEFAULT    = 32;
   localparam int unsigned POSITION_BITS_DEFAULT = 12;

   localparam int unsigned BYTE_BITS   = 8;
   localparam int unsigned BASE_BITS   = 6;
   localparam int unsigned STATUS_BITS = 2;
   localparam int unsigned PHASE_BITS  = 3;

   localparam logic [PHASE_BITS-1:0] PH_WS     = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_SIGNED = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_ZERO   = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_HEX1   = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_DIGITS = 3'd4;
   localparam logic [PHASE_BITS-1:0] PH_IGNORE = 3'd5;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NO_DIGITS = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_BAD_BASE  = 2'd3;

   localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_BITS-1:0] BASE_ONE  = 6'd1;
   localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
   localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;

   localparam logic [BASE_BITS-1:0] DIGIT_NONE = 6'd63;

   localparam logic [BYTE_BITS-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_BITS-1:0] CH_PLUS    = 8'h2B;
   localparam logic [BYTE_BITS-1:0] CH_MINUS   = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CH_X_LOWER = 8'h78;
   localparam logic [BYTE_BITS-1:0] CH_X_UPPER = 8'h58;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic [BASE_BITS-1:0]  active_base;
      logic                  negative_sign;
      logic                  overflowed;
      logic                  any_digit;
   } flags_type;

   function automatic logic is_blank(input logic [BYTE_BITS-1:0] c);
      logic r;
      case (c) inside
         8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [BASE_BITS-1:0] digit_of(input logic [BYTE_BITS-1:0] c);
      logic [BASE_BITS-1:0] d;
      logic [BYTE_BITS-1:0] t;
      t = '0;
      case (c) inside
         [8'h30:8'h39]: begin
            t = c - 8'h30;
            d = t[BASE_BITS-1:0];
         end
         [8'h61:8'h7A]: begin
            t = c - 8'h57;
            d = t[BASE_BITS-1:0];
         end
         [8'h41:8'h5A]: begin
            t = c - 8'h37;
            d = t[BASE_BITS-1:0];
         end
         default: d = DIGIT_NONE;
      endcase
      return d;
   endfunction

endpackage

[rtl/ascii_unsigned_number_parser.sv]
// Top level of the streaming ASCII to unsigned integer parser.
// Depends on anp_pkg and instantiates anp_step.
//
// The block takes one text byte per clock cycle and sustains that rate back to back while
// no result waits on a stalled output: each byte is registered, passes once through the
// step logic (one multiply by the radix and add of the digit value) and then updates the
// parse state, and each result is registered before it is delivered. Leading whitespace
// is skipped, one sign is taken (a minus negates the value), the base comes from the
// numeric_base register (zero detects 0x for hex and a leading 0 for octal), and
// exactly one result is delivered per string, either on the first byte that cannot
// continue the number or on the byte marked last. Bytes after a result are ignored up
// to the byte marked last. The register is sampled on the first byte of each string and
// may only be written while no string is in progress.
module ascii_unsigned_number_parser #(
   parameter int unsigned VALUE_BITS    = anp_pkg::VALUE_BITS_DEFAULT,
   parameter int unsigned POSITION_BITS = anp_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [anp_pkg::BASE_BITS-1:0]      csr_numeric_base,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [anp_pkg::BYTE_BITS-1:0]      req_text_byte,
   input  logic                               req_last_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [VALUE_BITS-1:0]              rsp_parsed_value,
   output logic [POSITION_BITS-1:0]           rsp_consumed_count,
   output logic [anp_pkg::STATUS_BITS-1:0]    rsp_status
);
   import anp_pkg::*;

   logic [BASE_BITS-1:0]     base_ff;
   logic                     s1_valid_ff, s1_valid_in;
   logic [BYTE_BITS-1:0]     s1_byte_ff;
   logic                     s1_last_ff;
   flags_type                flags_ff, flags_in;
   logic [VALUE_BITS-1:0]    acc_ff, acc_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0]    out_value_ff;
   logic [POSITION_BITS-1:0] out_count_ff;
   logic [STATUS_BITS-1:0]   out_status_ff;

   logic                     emit;
   logic [VALUE_BITS-1:0]    step_value;
   logic [POSITION_BITS-1:0] step_count;
   logic [STATUS_BITS-1:0]   step_status;
   logic                     out_free;
   logic                     advance;
   logic                     take_req;

   anp_step #(
      .VALUE_BITS    (VALUE_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_step (
      .flags_cur      (flags_ff),
      .acc_cur        (acc_ff),
      .pos_cur        (pos_ff),
      .numeric_base   (base_ff),
      .text_byte      (s1_byte_ff),
      .last_byte      (s1_last_ff),
      .flags_nxt      (flags_in),
      .acc_nxt        (acc_in),
      .pos_nxt        (pos_in),
      .emit           (emit),
      .parsed_value   (step_value),
      .consumed_count (step_count),
      .status         (step_status)
   );

   assign out_free     = !out_valid_ff || !rsp_stall;
   assign advance      = s1_valid_ff && (out_free || !emit);
   assign req_stall    = s1_valid_ff && !advance;
   assign take_req     = req_valid && !req_stall;
   assign s1_valid_in  = take_req || (s1_valid_ff && !advance);
   assign out_valid_in = (advance && emit) || (out_valid_ff && rsp_stall);

   assign csr_ready          = 1'b1;
   assign rsp_valid          = out_valid_ff;
   assign rsp_parsed_value   = out_value_ff;
   assign rsp_consumed_count = out_count_ff;
   assign rsp_status         = out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_AUTO;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
         acc_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) base_ff <= csr_numeric_base;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            flags_ff <= flags_in;
            acc_ff   <= acc_in;
            pos_ff   <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_byte_ff <= req_text_byte;
         s1_last_ff <= req_last_byte;
      end
      if (advance && emit) begin
         out_value_ff  <= step_value;
         out_count_ff  <= step_count;
         out_status_ff <= step_status;
      end
   end

endmodule

[rtl/anp_step.sv]
// Next-state and result logic of the parser for one text item.
// Depends on anp_pkg for codes, the flag struct and the character helpers.
module anp_step #(
   parameter int unsigned VALUE_BITS    = anp_pkg::VALUE_BITS_DEFAULT,
   parameter int unsigned POSITION_BITS = anp_pkg::POSITION_BITS_DEFAULT
) (
   input  anp_pkg::flags_type                   flags_cur,
   input  logic [VALUE_BITS-1:0]                acc_cur,
   input  logic [POSITION_BITS-1:0]             pos_cur,
   input  logic [anp_pkg::BASE_BITS-1:0]        numeric_base,
   input  logic [anp_pkg::BYTE_BITS-1:0]        text_byte,
   input  logic                                 last_byte,
   output anp_pkg::flags_type                   flags_nxt,
   output logic [VALUE_BITS-1:0]                acc_nxt,
   output logic [POSITION_BITS-1:0]             pos_nxt,
   output logic                                 emit,
   output logic [VALUE_BITS-1:0]                parsed_value,
   output logic [POSITION_BITS-1:0]             consumed_count,
   output logic [anp_pkg::STATUS_BITS-1:0]      status
);
   import anp_pkg::*;

   localparam int unsigned WIDE = VALUE_BITS + BASE_BITS + 1;
   localparam logic [POSITION_BITS-1:0] POS_FULL = {POSITION_BITS{1'b1}};

   always_comb begin
      flags_type            f;
      logic [VALUE_BITS-1:0]    acc;
      logic [POSITION_BITS-1:0] pos;
      logic [BASE_BITS-1:0]     d;
      logic [WIDE-1:0]          wide;
      logic                     first;
      logic                     sig_chk;
      logic                     dig_chk;
      logic                     dig_take;
      logic                     emit_now;

      f        = flags_cur;
      acc      = acc_cur;
      pos      = pos_cur;
      d        = digit_of(text_byte);
      wide     = '0;
      first    = (flags_cur.phase == PH_WS) && (pos_cur == '0);
      sig_chk  = 1'b0;
      dig_chk  = 1'b0;
      dig_take = 1'b0;
      emit_now = 1'b0;
      parsed_value   = '0;
      consumed_count = '0;
      status         = ST_OK;

      if (flags_cur.phase != PH_IGNORE) begin
         if (first) begin
            f.active_base = numeric_base;
         end
         if (first && (numeric_base == BASE_ONE || numeric_base > BASE_MAX)) begin
            emit_now = 1'b1;
            status   = ST_BAD_BASE;
         end else begin
            unique case (flags_cur.phase)
               PH_WS: begin
                  if (is_blank(text_byte)) begin
                     if (pos != POS_FULL) pos = pos + 1'b1;
                  end else if (text_byte == CH_PLUS || text_byte == CH_MINUS) begin
                     f.negative_sign = (text_byte == CH_MINUS);
                     if (pos != POS_FULL) pos = pos + 1'b1;
                     f.phase = PH_SIGNED;
                  end else begin
                     sig_chk = 1'b1;
                  end
               end
               PH_SIGNED: begin
                  sig_chk = 1'b1;
               end
               PH_ZERO: begin
                  if (text_byte == CH_X_LOWER || text_byte == CH_X_UPPER) begin
                     f.phase = PH_HEX1;
                  end else begin
                     if (f.active_base == BASE_AUTO) f.active_base = BASE_OCT;
                     dig_chk = 1'b1;
                  end
               end
               PH_HEX1: begin
                  f.active_base = BASE_HEX;
                  if (d < BASE_HEX) begin
                     if (pos != POS_FULL) pos = pos + 1'b1;
                     dig_take = 1'b1;
                     f.phase  = PH_DIGITS;
                  end else begin
                     emit_now = 1'b1;
                  end
               end
               PH_DIGITS: begin
                  dig_chk = 1'b1;
               end
               default: begin
                  f = flags_cur;
               end
            endcase

            if (sig_chk) begin
               if (text_byte == CH_ZERO &&
                   (f.active_base == BASE_AUTO || f.active_base == BASE_HEX)) begin
                  f.any_digit = 1'b1;
                  if (pos != POS_FULL) pos = pos + 1'b1;
                  f.phase = PH_ZERO;
               end else begin
                  if (f.active_base == BASE_AUTO) f.active_base = BASE_DEC;
                  dig_chk = 1'b1;
               end
            end

            if (dig_chk) begin
               f.phase = PH_DIGITS;
               if (d < f.active_base) begin
                  dig_take = 1'b1;
               end else begin
                  emit_now = 1'b1;
               end
            end

            if (dig_take) begin
               wide = WIDE'(acc) * WIDE'(f.active_base) + WIDE'(d);
               if (|wide[WIDE-1:VALUE_BITS]) begin
                  f.overflowed = 1'b1;
               end else begin
                  acc = wide[VALUE_BITS-1:0];
               end
               f.any_digit = 1'b1;
               if (pos != POS_FULL) pos = pos + 1'b1;
            end

            if (last_byte) emit_now = 1'b1;

            if (!f.any_digit) begin
               status = ST_NO_DIGITS;
            end else if (f.overflowed) begin
               parsed_value   = '1;
               consumed_count = pos;
               status         = ST_OVERFLOW;
            end else begin
               parsed_value   = f.negative_sign ? (~acc + VALUE_BITS'(1)) : acc;
               consumed_count = pos;
               status         = ST_OK;
            end
         end
      end

      if (emit_now) begin
         f.phase = PH_IGNORE;
      end

      emit = emit_now;
      if (last_byte && (emit_now || flags_cur.phase == PH_IGNORE)) begin
         flags_nxt = '0;
         acc_nxt   = '0;
         pos_nxt   = '0;
      end else begin
         flags_nxt = f;
         acc_nxt   = acc;
         pos_nxt   = pos;
      end
   end

endmodule

[rtl/anp_checker.sv]
// Port-level checks for the ASCII unsigned number parser, bound to its top level.
// Depends on anp_pkg for the status codes.
module anp_checker #(
   parameter int unsigned VALUE_BITS    = anp_pkg::VALUE_BITS_DEFAULT,
   parameter int unsigned POSITION_BITS = anp_pkg::POSITION_BITS_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [VALUE_BITS-1:0]              rsp_parsed_value,
   input logic [POSITION_BITS-1:0]           rsp_consumed_count,
   input logic [anp_pkg::STATUS_BITS-1:0]    rsp_status
);
   import anp_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result item valid after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_parsed_value)
         && $stable(rsp_status))
      else $error("Stalled result item changed.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NO_DIGITS || rsp_status == ST_BAD_BASE)
         |-> rsp_parsed_value == '0 && rsp_consumed_count == '0)
      else $error("Error item carries a value or a count.");

   a_overflow_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OVERFLOW
         |-> rsp_parsed_value == '1 && rsp_consumed_count != '0)
      else $error("Overflow item is not saturated.");

endmodule

bind ascii_unsigned_number_parser anp_checker #(
   .VALUE_BITS    (VALUE_BITS),
   .POSITION_BITS (POSITION_BITS)
) u_anp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_parsed_value   (rsp_parsed_value),
   .rsp_consumed_count (rsp_consumed_count),
   .rsp_status         (rsp_status)
);
